// ===== rtl/pan_tilt_stepper_and_shutter_sequencer_macros.svh =====
// assertion macros used by the sequencer top level
`ifndef PAN_TILT_STEPPER_AND_SHUTTER_SEQUENCER_MACROS_SVH
`define PAN_TILT_STEPPER_AND_SHUTTER_SEQUENCER_MACROS_SVH

// same-cycle implication, checked on every edge out of reset
`define PTS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pts assertion failed");

// next-cycle implication, checked on every edge out of reset
`define PTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pts assertion failed");

`endif

// ===== rtl/pts_pkg.sv =====
// shared types, codes, reset values and the pan phase table for the sequencer
`default_nettype none

package pts_pkg;

    // item kinds
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_MOVE_PAN  = 3'd1;
    localparam logic [2:0] KIND_MOVE_TILT = 3'd2;
    localparam logic [2:0] KIND_FOCUS     = 3'd3;
    localparam logic [2:0] KIND_SHOT      = 3'd4;

    // register indexes on the config port
    localparam logic [2:0] REG_X_STEP_SIZE = 3'd0;
    localparam logic [2:0] REG_Y_STEP_SIZE = 3'd1;
    localparam logic [2:0] REG_FOCUS_HOLD  = 3'd2;
    localparam logic [2:0] REG_SHOT_HOLD   = 3'd3;
    localparam logic [2:0] REG_SHOT_LEAD   = 3'd4;

    // camera event codes
    localparam logic [1:0] EV_NONE        = 2'd0;
    localparam logic [1:0] EV_FOCUS_START = 2'd1;
    localparam logic [1:0] EV_SHOT_START  = 2'd2;
    localparam logic [1:0] EV_SHOT_END    = 2'd3;

    // config reset values
    localparam logic [7:0]  X_STEP_SIZE_RST = 8'd9;
    localparam logic [7:0]  Y_STEP_SIZE_RST = 8'd10;
    localparam logic [15:0] FOCUS_HOLD_RST  = 16'd2000;
    localparam logic [15:0] SHOT_HOLD_RST   = 16'd600;
    localparam logic [15:0] SHOT_LEAD_RST   = 16'd100;

    // tilt axis reset angles, tenths of a degree
    localparam logic signed [15:0] TILT_POS_RST  = 16'sd1800;
    localparam logic signed [15:0] TILT_GOAL_RST = 16'sd900;

    // saturation limits of a 16-bit angle
    localparam logic signed [15:0] ANGLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] ANGLE_MIN = -16'sh8000;

    // pan half-step coil patterns
    localparam logic [5:0] PAN_TABLE [8] = '{
        6'h39, 6'h28, 6'h3A, 6'h12, 6'h36, 6'h24, 6'h35, 6'h11
    };

    // one registered item
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] goal_angle;
        logic               direction;
        logic [15:0]        step_delay;
    } t_item;

    // next result bits of one axis
    typedef struct packed {
        logic [5:0] coils;
        logic       busy;
    } t_axis_out;

    // next result bits of the camera timer
    typedef struct packed {
        logic       focus_line;
        logic       shutter_line;
        logic [1:0] event_res;
    } t_cam_out;

    // tilt coil word: control bits over a one-hot nibble
    function automatic logic [5:0] tilt_coil_word(input logic [1:0] phase);
        logic [1:0] ctrl;
        logic [3:0] nib;
        ctrl = phase[1] ? 2'd1 : 2'd2;
        nib  = 4'b1000 >> phase;
        return {ctrl, nib};
    endfunction

    // angle plus or minus a step, clamped to 16 bits
    function automatic logic signed [15:0] step_angle(
        input logic signed [15:0] pos,
        input logic [7:0]         step,
        input logic               ccw
    );
        logic signed [17:0] sum;
        logic signed [17:0] stp;
        stp = $signed({10'd0, step});
        sum = ccw ? ($signed({{2{pos[15]}}, pos}) - stp)
                  : ($signed({{2{pos[15]}}, pos}) + stp);
        if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111) begin
            return sum[15:0];
        end else if (sum[17]) begin
            return ANGLE_MIN;
        end else begin
            return ANGLE_MAX;
        end
    endfunction

    // true when the goal lies closer than one step
    function automatic logic within_step(
        input logic signed [15:0] goal,
        input logic signed [15:0] pos,
        input logic [7:0]         step
    );
        logic signed [16:0] diff;
        logic [16:0]        mag;
        diff = $signed({goal[15], goal}) - $signed({pos[15], pos});
        mag  = diff[16] ? 17'(-diff) : 17'(diff);
        return mag < {9'd0, step};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pts_pan_axis.sv =====
// pan axis: position, goal, step timing and half-step coil phase
`default_nettype none

module pts_pan_axis (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire pts_pkg::t_item i_item,
    input  wire logic [7:0]    i_step_size,
    output pts_pkg::t_axis_out o_next
);

    logic signed [15:0] r_pos, n_pos;
    logic signed [15:0] r_goal, n_goal;
    logic [15:0]        r_delay, n_delay;
    logic [15:0]        r_elapsed, n_elapsed;
    logic [2:0]         r_phase, n_phase;
    logic               r_dir, n_dir;
    logic [5:0]         r_coils, n_coils;
    logic               r_busy, n_busy;

    // next state for the item in the input register
    always_comb begin
        n_pos     = r_pos;
        n_goal    = r_goal;
        n_delay   = r_delay;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        n_dir     = r_dir;
        n_coils   = r_coils;
        n_busy    = r_busy;
        if (i_item.kind == pts_pkg::KIND_MOVE_PAN) begin
            n_goal    = i_item.goal_angle;
            n_dir     = i_item.direction;
            n_delay   = i_item.step_delay;
            n_elapsed = i_item.step_delay;
            n_busy    = 1'b1;
        end else if (i_item.kind == pts_pkg::KIND_TICK && r_busy) begin
            if (pts_pkg::within_step(r_goal, r_pos, i_step_size)) begin
                n_goal = r_pos;
            end else if (r_goal != r_pos) begin
                if (r_elapsed >= r_delay) begin
                    n_pos     = pts_pkg::step_angle(r_pos, i_step_size, r_dir);
                    n_phase   = r_dir ? r_phase - 3'd1 : r_phase + 3'd1;
                    n_coils   = pts_pkg::PAN_TABLE[n_phase];
                    n_elapsed = 16'd1;
                end else if (r_elapsed != 16'hFFFF) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
            end
            // arrival releases the coils
            if (n_goal == n_pos) begin
                n_coils = 6'd0;
                n_busy  = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_goal    <= '0;
            r_delay   <= '0;
            r_elapsed <= '0;
            r_phase   <= '0;
            r_dir     <= 1'b0;
            r_coils   <= '0;
            r_busy    <= 1'b0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_goal    <= n_goal;
            r_delay   <= n_delay;
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            r_dir     <= n_dir;
            r_coils   <= n_coils;
            r_busy    <= n_busy;
        end
    end

    assign o_next.coils = n_coils;
    assign o_next.busy  = n_busy;

endmodule

`default_nettype wire

// ===== rtl/pts_tilt_axis.sv =====
// tilt axis: position, goal, step timing and full-step coil phase
`default_nettype none

module pts_tilt_axis (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire pts_pkg::t_item i_item,
    input  wire logic [7:0]    i_step_size,
    output pts_pkg::t_axis_out o_next
);

    logic signed [15:0] r_pos, n_pos;
    logic signed [15:0] r_goal, n_goal;
    logic [15:0]        r_delay, n_delay;
    logic [15:0]        r_elapsed, n_elapsed;
    logic [1:0]         r_phase, n_phase;
    logic               r_dir, n_dir;
    logic [5:0]         r_coils, n_coils;
    logic               r_busy, n_busy;

    // next state for the item in the input register
    always_comb begin
        n_pos     = r_pos;
        n_goal    = r_goal;
        n_delay   = r_delay;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        n_dir     = r_dir;
        n_coils   = r_coils;
        n_busy    = r_busy;
        if (i_item.kind == pts_pkg::KIND_MOVE_TILT) begin
            n_goal    = i_item.goal_angle;
            n_dir     = i_item.direction;
            n_delay   = i_item.step_delay;
            n_elapsed = i_item.step_delay;
            n_busy    = 1'b1;
        end else if (i_item.kind == pts_pkg::KIND_TICK && r_busy) begin
            if (pts_pkg::within_step(r_goal, r_pos, i_step_size)) begin
                // snap onto the goal, coils stay energized
                n_pos = r_goal;
            end else if (r_goal != r_pos) begin
                if (r_elapsed >= r_delay) begin
                    n_pos     = pts_pkg::step_angle(r_pos, i_step_size, r_dir);
                    n_phase   = r_dir ? r_phase - 2'd1 : r_phase + 2'd1;
                    n_coils   = pts_pkg::tilt_coil_word(n_phase);
                    n_elapsed = 16'd1;
                end else if (r_elapsed != 16'hFFFF) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
            end
            if (n_goal == n_pos) begin
                n_busy = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= pts_pkg::TILT_POS_RST;
            r_goal    <= pts_pkg::TILT_GOAL_RST;
            r_delay   <= '0;
            r_elapsed <= '0;
            r_phase   <= '0;
            r_dir     <= 1'b0;
            r_coils   <= '0;
            r_busy    <= 1'b0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_goal    <= n_goal;
            r_delay   <= n_delay;
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            r_dir     <= n_dir;
            r_coils   <= n_coils;
            r_busy    <= n_busy;
        end
    end

    assign o_next.coils = n_coils;
    assign o_next.busy  = n_busy;

endmodule

`default_nettype wire

// ===== rtl/pts_camera.sv =====
// camera focus and shutter timing with pending and active flags
`default_nettype none

module pts_camera (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic [2:0]     i_kind,
    input  wire logic [15:0]    i_focus_hold,
    input  wire logic [15:0]    i_shot_hold,
    input  wire logic [15:0]    i_shot_lead,
    output pts_pkg::t_cam_out   o_next
);

    logic        r_focus_pend, n_focus_pend;
    logic        r_focus_held, n_focus_held;
    logic        r_shot_pend, n_shot_pend;
    logic        r_shot_act, n_shot_act;
    logic [15:0] r_focus_tmr, n_focus_tmr;
    logic [15:0] r_shot_tmr, n_shot_tmr;
    logic [15:0] r_lead_tmr, n_lead_tmr;
    logic [1:0]  w_event;

    // one camera action per tick, focus before shot
    always_comb begin
        n_focus_pend = r_focus_pend;
        n_focus_held = r_focus_held;
        n_shot_pend  = r_shot_pend;
        n_shot_act   = r_shot_act;
        n_focus_tmr  = r_focus_tmr;
        n_shot_tmr   = r_shot_tmr;
        n_lead_tmr   = r_lead_tmr;
        w_event      = pts_pkg::EV_NONE;
        case (i_kind)
            pts_pkg::KIND_TICK: begin
                if (r_focus_tmr != 16'd0) n_focus_tmr = r_focus_tmr - 16'd1;
                if (r_shot_tmr != 16'd0)  n_shot_tmr  = r_shot_tmr - 16'd1;
                if (r_lead_tmr != 16'd0)  n_lead_tmr  = r_lead_tmr - 16'd1;
                if (r_focus_pend) begin
                    n_focus_pend = 1'b0;
                    n_focus_held = 1'b1;
                    w_event      = pts_pkg::EV_FOCUS_START;
                end else if (r_focus_held) begin
                    if (r_focus_tmr == 16'd0) n_focus_held = 1'b0;
                end else if (r_shot_pend) begin
                    n_shot_pend = 1'b0;
                    n_shot_act  = 1'b1;
                    n_lead_tmr  = i_shot_lead;
                    w_event     = pts_pkg::EV_SHOT_START;
                end else if (r_shot_act && r_shot_tmr == 16'd0) begin
                    n_shot_act = 1'b0;
                    w_event    = pts_pkg::EV_SHOT_END;
                end
            end
            pts_pkg::KIND_FOCUS: begin
                n_focus_pend = 1'b1;
                n_focus_tmr  = i_focus_hold;
            end
            pts_pkg::KIND_SHOT: begin
                n_shot_pend = 1'b1;
                n_shot_tmr  = i_shot_hold;
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus_pend <= 1'b0;
            r_focus_held <= 1'b0;
            r_shot_pend  <= 1'b0;
            r_shot_act   <= 1'b0;
            r_focus_tmr  <= '0;
            r_shot_tmr   <= '0;
            r_lead_tmr   <= '0;
        end else if (i_fire) begin
            r_focus_pend <= n_focus_pend;
            r_focus_held <= n_focus_held;
            r_shot_pend  <= n_shot_pend;
            r_shot_act   <= n_shot_act;
            r_focus_tmr  <= n_focus_tmr;
            r_shot_tmr   <= n_shot_tmr;
            r_lead_tmr   <= n_lead_tmr;
        end
    end

    // active-low lines from the updated flags
    assign o_next.shutter_line = !n_shot_act;
    assign o_next.focus_line   = !(n_focus_held || (n_shot_act && n_lead_tmr == 16'd0));
    assign o_next.event_res    = w_event;

endmodule

`default_nettype wire

// ===== rtl/pan_tilt_stepper_and_shutter_sequencer.sv =====
// top level: input and result registers, config registers, axis and camera units
`default_nettype none
`include "pan_tilt_stepper_and_shutter_sequencer_macros.svh"

// Pan/tilt stepper and camera shutter sequencer. Every item (a millisecond
// tick or a command) produces exactly one result item holding the coil
// lines, camera lines, busy flags and event code after that item. An item
// is taken into an input register, then its state update and result are
// computed combinationally and written into the result register, and one
// item is accepted every cycle while the result side keeps up.
// The result register lets a new item enter while a finished result still
// waits; the input register holds its item while the result side stalls.
// Config registers (step sizes and camera hold/lead times) may be written
// only while no item is in flight.
module pan_tilt_stepper_and_shutter_sequencer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_kind,
    input  wire logic signed [15:0] i_goal_angle,
    input  wire logic               i_direction,
    input  wire logic [15:0]        i_step_delay,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [5:0]              o_pan_coils,
    output logic [5:0]              o_tilt_coils,
    output logic                    o_focus_line,
    output logic                    o_shutter_line,
    output logic                    o_pan_busy,
    output logic                    o_tilt_busy,
    output logic [1:0]              o_event_res,
    // config port
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    logic               r_in_valid;
    pts_pkg::t_item     r_in_item;
    logic               r_out_valid;
    logic [7:0]         r_x_step_size;
    logic [7:0]         r_y_step_size;
    logic [15:0]        r_focus_hold;
    logic [15:0]        r_shot_hold;
    logic [15:0]        r_shot_lead;
    logic               w_fire;
    logic               w_accept;
    pts_pkg::t_axis_out w_pan_next;
    pts_pkg::t_axis_out w_tilt_next;
    pts_pkg::t_cam_out  w_cam_next;

    // handshake: process when the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item.kind       <= i_kind;
            r_in_item.goal_angle <= i_goal_angle;
            r_in_item.direction  <= i_direction;
            r_in_item.step_delay <= i_step_delay;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_step_size <= pts_pkg::X_STEP_SIZE_RST;
            r_y_step_size <= pts_pkg::Y_STEP_SIZE_RST;
            r_focus_hold  <= pts_pkg::FOCUS_HOLD_RST;
            r_shot_hold   <= pts_pkg::SHOT_HOLD_RST;
            r_shot_lead   <= pts_pkg::SHOT_LEAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pts_pkg::REG_X_STEP_SIZE: r_x_step_size <= i_cfg_data[7:0];
                pts_pkg::REG_Y_STEP_SIZE: r_y_step_size <= i_cfg_data[7:0];
                pts_pkg::REG_FOCUS_HOLD:  r_focus_hold  <= i_cfg_data;
                pts_pkg::REG_SHOT_HOLD:   r_shot_hold   <= i_cfg_data;
                pts_pkg::REG_SHOT_LEAD:   r_shot_lead   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // processing units
    pts_pan_axis u_pan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in_item),
        .i_step_size (r_x_step_size),
        .o_next      (w_pan_next)
    );

    pts_tilt_axis u_tilt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in_item),
        .i_step_size (r_y_step_size),
        .o_next      (w_tilt_next)
    );

    pts_camera u_cam (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_kind       (r_in_item.kind),
        .i_focus_hold (r_focus_hold),
        .i_shot_hold  (r_shot_hold),
        .i_shot_lead  (r_shot_lead),
        .o_next       (w_cam_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_pan_coils    <= w_pan_next.coils;
            o_pan_busy     <= w_pan_next.busy;
            o_tilt_coils   <= w_tilt_next.coils;
            o_tilt_busy    <= w_tilt_next.busy;
            o_focus_line   <= w_cam_next.focus_line;
            o_shutter_line <= w_cam_next.shutter_line;
            o_event_res    <= w_cam_next.event_res;
        end
    end

    assign o_out_valid = r_out_valid;

    // checks on the sequencing logic
    `PTS_ASSERT_IMPL(a_pan_idle_released, r_out_valid && !o_pan_busy, o_pan_coils == 6'd0)
    `PTS_ASSERT_IMPL(a_tilt_nibble_onehot, r_out_valid, $onehot0(o_tilt_coils[3:0]))
    `PTS_ASSERT_IMPL(a_shot_start_low, r_out_valid && o_event_res == pts_pkg::EV_SHOT_START, !o_shutter_line)
    `PTS_ASSERT_IMPL(a_shot_end_high, r_out_valid && o_event_res == pts_pkg::EV_SHOT_END, o_shutter_line)
    `PTS_ASSERT_IMPL(a_focus_start_low, r_out_valid && o_event_res == pts_pkg::EV_FOCUS_START, !o_focus_line)
    `PTS_ASSERT_NEXT(a_fire_fills_result, w_fire, r_out_valid)

endmodule

`default_nettype wire

// ===== verif/pan_tilt_stepper_and_shutter_sequencer_tb.sv =====
// self-checking testbench for the pan/tilt stepper and camera shutter sequencer
module pan_tilt_stepper_and_shutter_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // kinds the block ignores
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    // coil words per phase, pan half steps and tilt full steps
    localparam logic [5:0] PAN_PHASE_COILS [8] = '{
        6'h39, 6'h28, 6'h3A, 6'h12, 6'h36, 6'h24, 6'h35, 6'h11
    };
    localparam logic [5:0] TILT_PHASE_COILS [4] = '{6'h28, 6'h24, 6'h12, 6'h11};

    // one result item as seen on the output ports
    typedef struct packed {
        logic [5:0] pan_coils;
        logic [5:0] tilt_coils;
        logic       focus_line;
        logic       shutter_line;
        logic       pan_busy;
        logic       tilt_busy;
        logic [1:0] event_res;
    } t_lines;

    // dut ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_kind = pts_pkg::KIND_TICK;
    logic signed [15:0] i_goal_angle = '0;
    logic               i_direction = 1'b0;
    logic [15:0]        i_step_delay = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [5:0]         o_pan_coils;
    logic [5:0]         o_tilt_coils;
    logic               o_focus_line;
    logic               o_shutter_line;
    logic               o_pan_busy;
    logic               o_tilt_busy;
    logic [1:0]         o_event_res;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = pts_pkg::REG_X_STEP_SIZE;
    logic [15:0]        i_cfg_data = '0;

    // register shadows
    logic [7:0]  cfg_pan_step = pts_pkg::X_STEP_SIZE_RST;
    logic [7:0]  cfg_tilt_step = pts_pkg::Y_STEP_SIZE_RST;
    logic [15:0] cfg_focus_hold = pts_pkg::FOCUS_HOLD_RST;
    logic [15:0] cfg_shot_hold = pts_pkg::SHOT_HOLD_RST;
    logic [15:0] cfg_shot_lead = pts_pkg::SHOT_LEAD_RST;

    // predicted axis state
    logic signed [15:0] pan_pos = '0;
    logic signed [15:0] pan_target = '0;
    logic [15:0]        pan_wait = '0;
    logic [15:0]        pan_count = '0;
    logic [2:0]         pan_ph = '0;
    logic               pan_ccw = 1'b0;
    logic [5:0]         pan_lines = '0;
    logic               pan_moving = 1'b0;
    logic signed [15:0] tilt_pos = pts_pkg::TILT_POS_RST;
    logic signed [15:0] tilt_target = pts_pkg::TILT_GOAL_RST;
    logic [15:0]        tilt_wait = '0;
    logic [15:0]        tilt_count = '0;
    logic [1:0]         tilt_ph = '0;
    logic               tilt_ccw = 1'b0;
    logic [5:0]         tilt_lines = '0;
    logic               tilt_moving = 1'b0;

    // predicted camera state
    logic        focus_pend = 1'b0;
    logic        focus_held = 1'b0;
    logic        shot_pend = 1'b0;
    logic        shot_act = 1'b0;
    logic [15:0] focus_left = '0;
    logic [15:0] shot_left = '0;
    logic [15:0] lead_left = '0;

    // expected output lines, oldest first
    t_lines expected_lines_q [$];

    // idling knobs and run counters
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int ignored_sent = 0;
    int reg_writes = 0;
    int results_seen = 0;
    int mismatches = 0;
    int focus_starts = 0;
    int shot_starts = 0;
    int shot_ends = 0;

    pan_tilt_stepper_and_shutter_sequencer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_goal_angle   (i_goal_angle),
        .i_direction    (i_direction),
        .i_step_delay   (i_step_delay),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pan_coils    (o_pan_coils),
        .o_tilt_coils   (o_tilt_coils),
        .o_focus_line   (o_focus_line),
        .o_shutter_line (o_shutter_line),
        .o_pan_busy     (o_pan_busy),
        .o_tilt_busy    (o_tilt_busy),
        .o_event_res    (o_event_res),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // absolute distance between two angles
    function automatic int angle_gap(logic signed [15:0] a, logic signed [15:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    // clamp to the 16-bit angle range
    function automatic logic signed [15:0] clamp_angle(int v);
        if (v > int'(pts_pkg::ANGLE_MAX)) return pts_pkg::ANGLE_MAX;
        if (v < int'(pts_pkg::ANGLE_MIN)) return pts_pkg::ANGLE_MIN;
        return 16'(v);
    endfunction

    // pan axis on one tick: stop near goal, else step when delay is up
    function automatic void advance_pan();
        if (!pan_moving) return;
        if (angle_gap(pan_target, pan_pos) < int'(cfg_pan_step)) begin
            pan_target = pan_pos;
        end else if (pan_target != pan_pos) begin
            if (pan_count >= pan_wait) begin
                if (!pan_ccw) begin
                    pan_pos = clamp_angle(int'(pan_pos) + int'(cfg_pan_step));
                    pan_ph  = pan_ph + 3'd1;
                end else begin
                    pan_pos = clamp_angle(int'(pan_pos) - int'(cfg_pan_step));
                    pan_ph  = pan_ph - 3'd1;
                end
                pan_lines = PAN_PHASE_COILS[pan_ph];
                pan_count = 16'd1;
            end else if (pan_count != 16'hFFFF) begin
                pan_count = pan_count + 16'd1;
            end
        end
        // on the goal: release coils and go idle
        if (pan_target == pan_pos) begin
            pan_lines  = '0;
            pan_moving = 1'b0;
        end
    endfunction

    // tilt axis on one tick: snap to goal when near, coils are kept
    function automatic void advance_tilt();
        if (!tilt_moving) return;
        if (angle_gap(tilt_target, tilt_pos) < int'(cfg_tilt_step)) begin
            tilt_pos = tilt_target;
        end else if (tilt_target != tilt_pos) begin
            if (tilt_count >= tilt_wait) begin
                if (!tilt_ccw) begin
                    tilt_pos = clamp_angle(int'(tilt_pos) + int'(cfg_tilt_step));
                    tilt_ph  = tilt_ph + 2'd1;
                end else begin
                    tilt_pos = clamp_angle(int'(tilt_pos) - int'(cfg_tilt_step));
                    tilt_ph  = tilt_ph - 2'd1;
                end
                tilt_lines = TILT_PHASE_COILS[tilt_ph];
                tilt_count = 16'd1;
            end else if (tilt_count != 16'hFFFF) begin
                tilt_count = tilt_count + 16'd1;
            end
        end
        if (tilt_target == tilt_pos) begin
            tilt_moving = 1'b0;
        end
    endfunction

    // camera timers on one tick, one action in priority order
    function automatic logic [1:0] advance_camera();
        logic       focus_done;
        logic       shot_done;
        logic [1:0] ev;
        focus_done = (focus_left == 16'd0);
        shot_done  = (shot_left == 16'd0);
        ev         = pts_pkg::EV_NONE;
        if (focus_left != 16'd0) focus_left = focus_left - 16'd1;
        if (shot_left != 16'd0) shot_left = shot_left - 16'd1;
        if (lead_left != 16'd0) lead_left = lead_left - 16'd1;
        if (focus_pend) begin
            focus_pend = 1'b0;
            focus_held = 1'b1;
            ev         = pts_pkg::EV_FOCUS_START;
        end else if (focus_held) begin
            if (focus_done) focus_held = 1'b0;
        end else if (shot_pend) begin
            shot_pend = 1'b0;
            shot_act  = 1'b1;
            lead_left = cfg_shot_lead;
            ev        = pts_pkg::EV_SHOT_START;
        end else if (shot_act) begin
            if (shot_done) begin
                shot_act = 1'b0;
                ev       = pts_pkg::EV_SHOT_END;
            end
        end
        return ev;
    endfunction

    // apply one item to the predicted state and return the lines after it
    function automatic t_lines predict_sequencer_lines(
        logic [2:0]         kind,
        logic signed [15:0] goal,
        logic               dir,
        logic [15:0]        delay
    );
        t_lines r;
        logic [1:0] ev;
        ev = pts_pkg::EV_NONE;
        case (kind)
            pts_pkg::KIND_TICK: begin
                advance_pan();
                advance_tilt();
                ev = advance_camera();
            end
            pts_pkg::KIND_MOVE_PAN: begin
                pan_target = goal;
                pan_ccw    = dir;
                pan_wait   = delay;
                pan_count  = delay;
                pan_moving = 1'b1;
            end
            pts_pkg::KIND_MOVE_TILT: begin
                tilt_target = goal;
                tilt_ccw    = dir;
                tilt_wait   = delay;
                tilt_count  = delay;
                tilt_moving = 1'b1;
            end
            pts_pkg::KIND_FOCUS: begin
                focus_pend = 1'b1;
                focus_left = cfg_focus_hold;
            end
            pts_pkg::KIND_SHOT: begin
                shot_pend = 1'b1;
                shot_left = cfg_shot_hold;
            end
            default: ;
        endcase
        r.pan_coils    = pan_lines;
        r.tilt_coils   = tilt_lines;
        r.shutter_line = !shot_act;
        r.focus_line   = !(focus_held || (shot_act && lead_left == 16'd0));
        r.pan_busy     = pan_moving;
        r.tilt_busy    = tilt_moving;
        r.event_res    = ev;
        return r;
    endfunction

    // receiver stalls at the current rate
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_lines got;
        t_lines want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            got = {o_pan_coils, o_tilt_coils, o_focus_line, o_shutter_line,
                   o_pan_busy, o_tilt_busy, o_event_res};
            results_seen++;
            if (expected_lines_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result item %0d: %h", results_seen, got);
                end
            end else begin
                want = expected_lines_q.pop_front();
                case (want.event_res)
                    pts_pkg::EV_FOCUS_START: focus_starts++;
                    pts_pkg::EV_SHOT_START:  shot_starts++;
                    pts_pkg::EV_SHOT_END:    shot_ends++;
                    default: ;
                endcase
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d (expected / actual): pan %h/%h tilt %h/%h",
                                 results_seen, want.pan_coils, got.pan_coils,
                                 want.tilt_coils, got.tilt_coils);
                        $display("  focus %b/%b shutter %b/%b pan_busy %b/%b",
                                 want.focus_line, got.focus_line,
                                 want.shutter_line, got.shutter_line,
                                 want.pan_busy, got.pan_busy);
                        $display("  tilt_busy %b/%b event %0d/%0d",
                                 want.tilt_busy, got.tilt_busy,
                                 want.event_res, got.event_res);
                    end
                end
            end
        end
    end

    // send one item, with random idle cycles ahead of it
    task automatic send_item(
        input logic [2:0]         kind,
        input logic signed [15:0] goal,
        input logic               dir,
        input logic [15:0]        delay
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_goal_angle <= goal;
        i_direction  <= dir;
        i_step_delay <= delay;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_lines_q.push_back(predict_sequencer_lines(kind, goal, dir, delay));
        items_sent++;
    endtask

    // ticks with random don't-care fields
    task automatic send_ticks(input int n);
        repeat (n) send_item(pts_pkg::KIND_TICK, 16'($urandom), 1'($urandom), 16'($urandom));
    endtask

    // hold off until every result is back and the pipe is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_lines_q.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // register write, only with nothing in flight
    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            pts_pkg::REG_X_STEP_SIZE: cfg_pan_step = value[7:0];
            pts_pkg::REG_Y_STEP_SIZE: cfg_tilt_step = value[7:0];
            pts_pkg::REG_FOCUS_HOLD:  cfg_focus_hold = value;
            pts_pkg::REG_SHOT_HOLD:   cfg_shot_hold = value;
            pts_pkg::REG_SHOT_LEAD:   cfg_shot_lead = value;
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(
        input logic [7:0]  x_step,
        input logic [7:0]  y_step,
        input logic [15:0] f_hold,
        input logic [15:0] s_hold,
        input logic [15:0] s_lead
    );
        write_reg(pts_pkg::REG_X_STEP_SIZE, {8'd0, x_step});
        write_reg(pts_pkg::REG_Y_STEP_SIZE, {8'd0, y_step});
        write_reg(pts_pkg::REG_FOCUS_HOLD, f_hold);
        write_reg(pts_pkg::REG_SHOT_HOLD, s_hold);
        write_reg(pts_pkg::REG_SHOT_LEAD, s_lead);
    endtask

    // reset state: ticks do nothing, undefined kinds are ignored
    task automatic test_reset_state();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_ticks(3);
        for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++) begin
            send_item(3'(k), 16'($urandom), 1'($urandom), 16'($urandom));
            ignored_sent++;
        end
        send_ticks(2);
    endtask

    // directed moves: both directions, near-goal stop, extreme goals and delays
    task automatic test_axis_moves();
        send_item(pts_pkg::KIND_MOVE_PAN, 16'sd30, 1'b0, 16'd0);
        send_ticks(5);
        send_item(pts_pkg::KIND_MOVE_PAN, -16'sd20, 1'b1, 16'd2);
        send_ticks(6);
        send_item(pts_pkg::KIND_MOVE_TILT, 16'sd900, 1'b1, 16'd1);
        send_ticks(4);
        send_item(pts_pkg::KIND_MOVE_TILT, 16'sd1800, 1'b0, 16'd0);
        send_ticks(3);
        // goal inside one step: tilt snaps, pan stops in place
        send_item(pts_pkg::KIND_MOVE_TILT, clamp_angle(int'(tilt_pos) + 5), 1'b0, 16'd0);
        send_item(pts_pkg::KIND_MOVE_PAN, clamp_angle(int'(pan_pos) - 4), 1'b1, 16'd0);
        send_ticks(2);
        send_item(pts_pkg::KIND_MOVE_PAN, pts_pkg::ANGLE_MAX, 1'b0, 16'hFFFF);
        send_item(pts_pkg::KIND_MOVE_TILT, pts_pkg::ANGLE_MIN, 1'b1, 16'hFFFF);
        send_ticks(3);
    endtask

    // focus and shot ordering, lead time, repeated commands
    task automatic test_camera_timing();
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        write_reg(pts_pkg::REG_FOCUS_HOLD, 16'd3);
        write_reg(pts_pkg::REG_SHOT_HOLD, 16'd6);
        write_reg(pts_pkg::REG_SHOT_LEAD, 16'd2);
        send_item(pts_pkg::KIND_FOCUS, '0, 1'b0, '0);
        send_ticks(6);
        send_item(pts_pkg::KIND_SHOT, '0, 1'b0, '0);
        send_ticks(9);
        // shot waits behind focus
        send_item(pts_pkg::KIND_FOCUS, '0, 1'b0, '0);
        send_item(pts_pkg::KIND_SHOT, '0, 1'b0, '0);
        send_ticks(14);
        // repeated shot and focus reload their timers
        send_item(pts_pkg::KIND_SHOT, '0, 1'b0, '0);
        send_ticks(2);
        send_item(pts_pkg::KIND_SHOT, '0, 1'b0, '0);
        send_ticks(10);
        send_item(pts_pkg::KIND_FOCUS, '0, 1'b0, '0);
        send_ticks(1);
        send_item(pts_pkg::KIND_FOCUS, '0, 1'b0, '0);
        send_ticks(6);
        // zero hold and lead
        write_reg(pts_pkg::REG_FOCUS_HOLD, 16'd0);
        write_reg(pts_pkg::REG_SHOT_HOLD, 16'd0);
        write_reg(pts_pkg::REG_SHOT_LEAD, 16'd0);
        send_item(pts_pkg::KIND_FOCUS, '0, 1'b0, '0);
        send_item(pts_pkg::KIND_SHOT, '0, 1'b0, '0);
        send_ticks(6);
    endtask

    // zero step size: axis steps in place and stays busy
    task automatic test_zero_step();
        send_idle_pct  = 0;
        recv_stall_pct = 54;
        write_reg(pts_pkg::REG_X_STEP_SIZE, 16'd0);
        write_reg(pts_pkg::REG_Y_STEP_SIZE, 16'd0);
        send_item(pts_pkg::KIND_MOVE_PAN, clamp_angle(int'(pan_pos) + 50), 1'b0, 16'd0);
        send_item(pts_pkg::KIND_MOVE_TILT, clamp_angle(int'(tilt_pos) - 50), 1'b1, 16'd1);
        send_ticks(5);
        // goal on the position ends the move
        send_item(pts_pkg::KIND_MOVE_PAN, pan_pos, 1'b0, 16'd0);
        send_item(pts_pkg::KIND_MOVE_TILT, tilt_pos, 1'b1, 16'd0);
        send_ticks(2);
    endtask

    // wrong direction runs into both angle limits
    task automatic test_angle_saturation();
        send_idle_pct  = 54;
        recv_stall_pct = 0;
        write_reg(pts_pkg::REG_X_STEP_SIZE, 16'd255);
        write_reg(pts_pkg::REG_Y_STEP_SIZE, 16'd255);
        send_item(pts_pkg::KIND_MOVE_PAN, pts_pkg::ANGLE_MIN, 1'b0, 16'd0);
        send_item(pts_pkg::KIND_MOVE_TILT, pts_pkg::ANGLE_MAX, 1'b1, 16'd0);
        send_ticks(140);
        send_item(pts_pkg::KIND_MOVE_PAN, pts_pkg::ANGLE_MAX, 1'b1, 16'd0);
        send_item(pts_pkg::KIND_MOVE_TILT, pts_pkg::ANGLE_MIN, 1'b0, 16'd0);
        send_ticks(270);
        // back toward the middle
        send_item(pts_pkg::KIND_MOVE_PAN, 16'sd0, 1'b0, 16'd0);
        send_item(pts_pkg::KIND_MOVE_TILT, 16'sd900, 1'b1, 16'd0);
        send_ticks(140);
    endtask

    // register extremes, then small timers reloaded by fresh commands
    task automatic test_register_extremes();
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        write_all_regs(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(pts_pkg::KIND_FOCUS, '0, 1'b0, '0);
        send_item(pts_pkg::KIND_SHOT, '0, 1'b0, '0);
        send_item(pts_pkg::KIND_MOVE_PAN, clamp_angle(int'(pan_pos) + 1000), 1'b0, 16'd0);
        send_ticks(6);
        write_all_regs(8'd1, 8'd1, 16'd1, 16'd1, 16'd1);
        send_item(pts_pkg::KIND_MOVE_TILT, clamp_angle(int'(tilt_pos) - 3), 1'b1, 16'd0);
        send_item(pts_pkg::KIND_FOCUS, '0, 1'b0, '0);
        send_item(pts_pkg::KIND_SHOT, '0, 1'b0, '0);
        send_ticks(10);
    endtask

    // random move toward a reachable goal, sometimes broken
    task automatic random_move(input logic on_tilt);
        logic signed [15:0] from;
        logic signed [15:0] goal;
        logic               dir;
        logic [15:0]        delay;
        int                 span;
        int                 g;
        from = on_tilt ? tilt_pos : pan_pos;
        span = int'(on_tilt ? cfg_tilt_step : cfg_pan_step) * int'($urandom_range(0, 12))
               + int'($urandom_range(0, 8));
        g = int'(from) + int'($urandom_range(0, 2 * span)) - span;
        if ($urandom_range(19) == 0) g = $signed(16'($urandom));
        goal = clamp_angle(g);
        dir  = (goal < from);
        if ($urandom_range(9) == 0) dir = !dir;
        delay = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        send_item(on_tilt ? pts_pkg::KIND_MOVE_TILT : pts_pkg::KIND_MOVE_PAN,
                  goal, dir, delay);
    endtask

    // random phases: new settings each phase, an optional command then a run of ticks
    task automatic test_random_traffic(input int per_phase);
        int start;
        int sel;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            write_all_regs(($urandom_range(3) == 0) ? 8'(255 * $urandom_range(1)) :
                               8'($urandom_range(1, 255)),
                           ($urandom_range(3) == 0) ? 8'(255 * $urandom_range(1)) :
                               8'($urandom_range(1, 255)),
                           16'($urandom_range(0, 24)), 16'($urandom_range(0, 40)),
                           16'($urandom_range(0, 20)));
            start = items_sent - ignored_sent;
            while (items_sent - ignored_sent - start < per_phase) begin
                sel = $urandom_range(99);
                if (sel < 30) begin
                    random_move(1'b0);
                end else if (sel < 60) begin
                    random_move(1'b1);
                end else if (sel < 72) begin
                    send_item(pts_pkg::KIND_FOCUS, 16'($urandom), 1'($urandom),
                              16'($urandom));
                end else if (sel < 84) begin
                    send_item(pts_pkg::KIND_SHOT, 16'($urandom), 1'($urandom),
                              16'($urandom));
                end else if (sel < 90) begin
                    send_item(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
                              16'($urandom), 1'($urandom), 16'($urandom));
                    ignored_sent++;
                end
                send_ticks($urandom_range(1, 12));
                // now and then the sender holds off until all results are back
                if ($urandom_range(49) == 0) drain();
            end
        end
    endtask

    // run the tests in turn
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_axis_moves();
        test_camera_timing();
        test_zero_step();
        test_angle_saturation();
        test_register_extremes();
        test_random_traffic(200);
        drain();
        repeat (8) @(posedge i_clk);
        $display("sent %0d items (%0d of undefined kind), checked %0d results,",
                 items_sent, ignored_sent, results_seen);
        $display("  %0d register writes, %0d focus starts, %0d shot starts, %0d shot ends",
                 reg_writes, focus_starts, shot_starts, shot_ends);
        if (mismatches == 0 && expected_lines_q.size() == 0) begin
            $display("pan_tilt_stepper_and_shutter_sequencer test passed");
        end else begin
            $display("pan_tilt_stepper_and_shutter_sequencer test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("pan_tilt_stepper_and_shutter_sequencer test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_pan_axis.sv
rtl/pts_tilt_axis.sv
rtl/pts_camera.sv
rtl/pan_tilt_stepper_and_shutter_sequencer.sv
verif/pan_tilt_stepper_and_shutter_sequencer_tb.sv
